>>> rtl/mesh_label_hole_fill_unit_defines.svh
// ----------------------------------------------------------------------------
// mesh_label_hole_fill_unit_defines.svh
// Assertion macros shared by the mesh label hole fill RTL.
// ----------------------------------------------------------------------------
`ifndef MESH_LABEL_HOLE_FILL_UNIT_DEFINES_SVH
`define MESH_LABEL_HOLE_FILL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define MLHF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define MLHF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define MLHF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MLHF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> rtl/mlhf_pkg.sv
// ----------------------------------------------------------------------------
// mlhf_pkg
// Shared constants and types of the mesh label hole fill unit.
// ----------------------------------------------------------------------------
package mlhf_pkg;

    // Field widths
    localparam int NODE_W  = 10;
    localparam int LABEL_W = 8;
    localparam int OP_W    = 2;

    localparam int NODE_COUNT_DEF = 1024;

    // Operation codes carried in tuser
    localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Triangle corners, one memory access each
    localparam int CORNERS = 3;
    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'(CORNERS - 1);

    // Stream payload widths, packed and rounded up to whole bytes
    localparam int IN_FIELDS_W  = 3 * NODE_W + LABEL_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LABEL_W + 1;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Each memory entry holds an epoch tag above the label.
    // Epoch zero marks an entry as never written in the current life.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
    localparam int ENTRY_W = EPOCH_W + LABEL_W;

    // Result buffer
    localparam int OUT_DEPTH = 2;
    localparam int CREDIT_W  = $clog2(OUT_DEPTH + 1);
    localparam int PTR_W     = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

    // Tag that travels alongside a fill read
    typedef struct packed {
        logic               vld;
        logic [1:0]         corner;
        logic               in_range;
        logic [LABEL_W-1:0] own_label;
    } fill_tag_t;

    // One result item
    typedef struct packed {
        logic               was_filled;
        logic [LABEL_W-1:0] new_label;
    } result_t;

endpackage

>>> rtl/mesh_label_hole_fill_unit.sv
// ----------------------------------------------------------------------------
// mesh_label_hole_fill_unit
// Label hole filling on a triangle mesh, node labels kept in one RAM.
// ----------------------------------------------------------------------------
// A mark or fill triangle takes one RAM access per corner, in order, set by the
// single port of the node label RAM; a new triangle is taken while the
// previous one's last read is still being evaluated. A clear item or a mark
// with label 0 is finished as soon as it is issued. Clear bumps an epoch tag
// stored with every label instead of touching the RAM. After reset, and after
// every 255th clear when the epoch wraps, a clearing pass writes the whole RAM,
// address by address, while no item is started. Fill results go through a
// 2-entry buffer; a fill waits when both are claimed.
// ----------------------------------------------------------------------------
module mesh_label_hole_fill_unit #(
    parameter int NODE_COUNT = mlhf_pkg::NODE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input triangles
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mlhf_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // node_a, node_b, node_c, label
    input  logic [mlhf_pkg::OP_W-1:0]       s_axis_tuser,  // op
    // results
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mlhf_pkg::OUT_DATA_W-1:0] m_axis_tdata   // new_label, was_filled
);

    localparam int ADDR_W = $clog2(NODE_COUNT);

    logic                         mem_en, mem_we;
    logic [ADDR_W-1:0]            mem_addr;
    logic [mlhf_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;
    mlhf_pkg::fill_tag_t          tag;
    logic [mlhf_pkg::EPOCH_W-1:0] epoch;
    logic                         out_pop;

    // Sequencer
    mlhf_seq #(
        .NODE_COUNT (NODE_COUNT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .out_pop   (out_pop),
        .mem_en    (mem_en),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .tag       (tag),
        .epoch     (epoch)
    );

    // Node label RAM
    mlhf_node_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Fill evaluator and result buffer
    mlhf_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .epoch     (epoch),
        .rdata     (mem_rdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_pop   (out_pop)
    );

endmodule

>>> rtl/mlhf_node_mem.sv
// ----------------------------------------------------------------------------
// mlhf_node_mem
// Single-port node label RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module mlhf_node_mem #(
    parameter int NODE_COUNT = mlhf_pkg::NODE_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         we,
    input  logic [$clog2(NODE_COUNT)-1:0] addr,
    input  logic [mlhf_pkg::ENTRY_W-1:0] wdata,
    output logic [mlhf_pkg::ENTRY_W-1:0] rdata
);

    logic [mlhf_pkg::ENTRY_W-1:0] mem [NODE_COUNT];
    logic [mlhf_pkg::ENTRY_W-1:0] rdata_reg;

    // Read or write, never both
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mlhf_seq.sv
// ----------------------------------------------------------------------------
// mlhf_seq
// Item sequencer: holds one triangle, drives the node RAM port one corner per cycle unless
// a clearing pass or a full result buffer holds it, keeps the label epoch and runs the RAM clearing pass.
// ----------------------------------------------------------------------------
`include "mesh_label_hole_fill_unit_defines.svh"

module mlhf_seq #(
    parameter int NODE_COUNT = mlhf_pkg::NODE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input transaction
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mlhf_pkg::IN_DATA_W-1:0] in_data,
    input  logic [mlhf_pkg::OP_W-1:0]      in_op,
    // result delivered on the output side
    input  logic                           out_pop,
    // node RAM port
    output logic                           mem_en,
    output logic                           mem_we,
    output logic [$clog2(NODE_COUNT)-1:0]  mem_addr,
    output logic [mlhf_pkg::ENTRY_W-1:0]   mem_wdata,
    // to the evaluator
    output mlhf_pkg::fill_tag_t            tag,
    output logic [mlhf_pkg::EPOCH_W-1:0]   epoch
);

    localparam int ADDR_W = $clog2(NODE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(NODE_COUNT - 1);
    localparam logic [31:0]       NODE_LIMIT = 32'(NODE_COUNT);
    localparam int NW = mlhf_pkg::NODE_W;
    localparam int LW = mlhf_pkg::LABEL_W;

    // Held item
    logic                        item_vld_reg;
    logic [mlhf_pkg::OP_W-1:0]   op_reg;
    logic [NW-1:0]               node_a_reg, node_b_reg, node_c_reg;
    logic [LW-1:0]               label_reg;
    logic [1:0]                  step_reg, step_next;

    // Epoch, clearing pass and result credits
    logic [mlhf_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic                         sweep_reg, sweep_next;
    logic [ADDR_W-1:0]            sweep_cnt_reg, sweep_cnt_next;
    logic [mlhf_pkg::CREDIT_W-1:0] pend_reg, pend_next;

    logic          is_mark, is_fill, is_clear, multi;
    logic          go, done, reserve, accept;
    logic [NW-1:0] cur_node;
    logic          in_range;
    logic [ADDR_W+NW-1:0] addr_wide;

    // Decode of the held item
    assign is_mark  = (op_reg == mlhf_pkg::OP_MARK) && (label_reg != '0);
    assign is_fill  = (op_reg == mlhf_pkg::OP_FILL);
    assign is_clear = (op_reg == mlhf_pkg::OP_CLEAR);
    assign multi    = is_mark || is_fill;

    // A fill only starts when a result slot is free
    assign go = item_vld_reg && !sweep_reg &&
                !(is_fill && (step_reg == mlhf_pkg::CORNER_FIRST) &&
                  (pend_reg >= mlhf_pkg::CREDIT_W'(mlhf_pkg::OUT_DEPTH)));
    assign done     = go && (!multi || (step_reg == mlhf_pkg::CORNER_LAST));
    assign reserve  = go && is_fill && (step_reg == mlhf_pkg::CORNER_FIRST);
    assign in_ready = !item_vld_reg || done;
    assign accept   = in_valid && in_ready;

    // Corner select
    always_comb
    begin
        unique case (step_reg)
            2'd0:    cur_node = node_a_reg;
            2'd1:    cur_node = node_b_reg;
            2'd2:    cur_node = node_c_reg;
            default: cur_node = node_a_reg;
        endcase
    end

    assign in_range  = (32'(cur_node) < NODE_LIMIT);
    assign addr_wide = {{ADDR_W{1'b0}}, cur_node};

    // RAM port: clearing pass has the port, else the current corner
    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = addr_wide[ADDR_W-1:0];
        mem_wdata = {epoch_reg, label_reg};
        if (sweep_reg)
        begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = sweep_cnt_reg;
            mem_wdata = '0;
        end
        else if (go && is_mark)
        begin
            mem_en = in_range;
            mem_we = 1'b1;
        end
        else if (go && is_fill)
        begin
            mem_en = in_range;
        end
    end

    // Tag for the read issued this cycle
    always_comb
    begin
        tag.vld       = go && is_fill;
        tag.corner    = step_reg;
        tag.in_range  = in_range;
        tag.own_label = label_reg;
    end

    assign epoch = epoch_reg;

    // Next state
    always_comb
    begin
        step_next      = step_reg;
        epoch_next     = epoch_reg;
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        pend_next      = pend_reg + mlhf_pkg::CREDIT_W'(reserve)
                                  - mlhf_pkg::CREDIT_W'(out_pop);

        if (go && multi)
        begin
            step_next = (step_reg == mlhf_pkg::CORNER_LAST) ? mlhf_pkg::CORNER_FIRST
                                                            : step_reg + 2'd1;
        end

        // Clear bumps the epoch; on wrap the RAM is swept back to epoch zero
        if (go && is_clear)
        begin
            if (epoch_reg == mlhf_pkg::EPOCH_MAX)
            begin
                epoch_next     = mlhf_pkg::EPOCH_FIRST;
                sweep_next     = 1'b1;
                sweep_cnt_next = '0;
            end
            else
            begin
                epoch_next = epoch_reg + mlhf_pkg::EPOCH_W'(1);
            end
        end

        if (sweep_reg)
        begin
            if (sweep_cnt_reg == LAST_ADDR)
            begin
                sweep_next = 1'b0;
            end
            sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg  <= 1'b0;
            step_reg      <= mlhf_pkg::CORNER_FIRST;
            epoch_reg     <= mlhf_pkg::EPOCH_FIRST;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (done)
            begin
                item_vld_reg <= 1'b0;
            end
            step_reg      <= step_next;
            epoch_reg     <= epoch_next;
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
            pend_reg      <= pend_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= in_op;
            node_a_reg <= in_data[NW-1:0];
            node_b_reg <= in_data[2*NW-1:NW];
            node_c_reg <= in_data[3*NW-1:2*NW];
            label_reg  <= in_data[3*NW+LW-1:3*NW];
        end
    end

    // Assertions
    `MLHF_ASSERT(a_credit_bound, clk, rst_n, pend_reg <= mlhf_pkg::CREDIT_W'(mlhf_pkg::OUT_DEPTH), "result credits exceed buffer depth")
    `MLHF_ASSERT(a_sweep_blocks_items, clk, rst_n, sweep_reg |-> !go, "item issued during clearing pass")
    `MLHF_ASSERT(a_wrap_starts_sweep, clk, rst_n, (go && is_clear && (epoch_reg == mlhf_pkg::EPOCH_MAX)) |=> (sweep_reg && (epoch_reg == mlhf_pkg::EPOCH_FIRST)), "epoch wrap without clearing pass")

endmodule

>>> rtl/mlhf_eval.sv
// ----------------------------------------------------------------------------
// mlhf_eval
// Fill evaluator: checks returned node entries against the epoch, compares
// the three corner labels and queues the result in a small output buffer.
// ----------------------------------------------------------------------------
`include "mesh_label_hole_fill_unit_defines.svh"

module mlhf_eval (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mlhf_pkg::fill_tag_t             tag,
    input  logic [mlhf_pkg::EPOCH_W-1:0]    epoch,
    input  logic [mlhf_pkg::ENTRY_W-1:0]    rdata,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mlhf_pkg::OUT_DATA_W-1:0] out_data,
    output logic                            out_pop
);

    localparam int LW = mlhf_pkg::LABEL_W;
    localparam int PW = mlhf_pkg::PTR_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(mlhf_pkg::OUT_DEPTH - 1);

    mlhf_pkg::fill_tag_t tag_reg;
    logic [LW-1:0]       first_reg;
    logic                ok_reg;

    logic [LW-1:0]                rd_label;
    logic [mlhf_pkg::EPOCH_W-1:0] rd_epoch;
    logic                         hit, same, resolved, push;
    mlhf_pkg::result_t            res;

    mlhf_pkg::result_t             fifo_reg [mlhf_pkg::OUT_DEPTH];
    logic [PW-1:0]                 wr_ptr_reg, rd_ptr_reg;
    logic [mlhf_pkg::CREDIT_W-1:0] count_reg;

    // Tag aligned with the registered RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    assign rd_label = rdata[LW-1:0];
    assign rd_epoch = rdata[mlhf_pkg::ENTRY_W-1:LW];

    // Node counts as labelled only when written since the last clear
    assign hit      = tag_reg.vld && tag_reg.in_range && (rd_epoch == epoch);
    assign same     = (rd_label == first_reg);
    assign resolved = ok_reg && hit && same;
    assign push     = tag_reg.vld && (tag_reg.corner == mlhf_pkg::CORNER_LAST);

    // Accumulate over corners
    always_ff @(posedge clk)
    begin
        if (tag_reg.vld)
        begin
            if (tag_reg.corner == mlhf_pkg::CORNER_FIRST)
            begin
                first_reg <= rd_label;
                ok_reg    <= hit;
            end
            else
            begin
                ok_reg <= resolved;
            end
        end
    end

    // Result selection: own label first, then the common node label
    always_comb
    begin
        if (tag_reg.own_label != '0)
        begin
            res.new_label  = tag_reg.own_label;
            res.was_filled = 1'b0;
        end
        else if (resolved)
        begin
            res.new_label  = first_reg;
            res.was_filled = 1'b1;
        end
        else
        begin
            res.new_label  = '0;
            res.was_filled = 1'b0;
        end
    end

    // Output buffer
    assign out_valid = (count_reg != '0);
    assign out_pop   = out_valid && out_ready;
    assign out_data  = {{(mlhf_pkg::OUT_DATA_W - mlhf_pkg::OUT_FIELDS_W){1'b0}},
                        fifo_reg[rd_ptr_reg]};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (out_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + mlhf_pkg::CREDIT_W'(push)
                                   - mlhf_pkg::CREDIT_W'(out_pop);
        end
    end

    // Assertions
    `MLHF_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && !out_pop && (count_reg == mlhf_pkg::CREDIT_W'(mlhf_pkg::OUT_DEPTH)), "result buffer overflow")
    `MLHF_ASSERT(a_corner_order, clk, rst_n, (tag_reg.vld && (tag_reg.corner == mlhf_pkg::CORNER_LAST)) |-> $past(tag_reg.vld && (tag_reg.corner == 2'd1)), "last corner without middle corner")
    `MLHF_ASSERT(a_filled_nonzero, clk, rst_n, (push && res.was_filled) |-> (res.new_label != '0), "filled result with zero label")

endmodule
